### rtl/dag_pkg.sv
// Shared types, constants and arithmetic helpers for the distance attenuation gain block.
// Has no dependencies; every other file of the block uses it by scoped names.
package dag_pkg;

   localparam int DISTANCE_WIDTH     = 24;
   localparam int GAIN_FRACTION_BITS = 15;
   localparam int ROLL_WIDTH         = 16;
   localparam int MODEL_WIDTH        = 2;
   localparam int GAIN_WIDTH         = GAIN_FRACTION_BITS + 1;
   localparam int LOG_FRAC           = 16;
   localparam int MANT_WIDTH         = 31;
   localparam int POS_WIDTH          = $clog2(DISTANCE_WIDTH);
   localparam int LOG_WIDTH          = POS_WIDTH + LOG_FRAC;
   localparam int NUM_WIDTH          = DISTANCE_WIDTH + 8;
   localparam int PROD_WIDTH         = DISTANCE_WIDTH + ROLL_WIDTH;
   localparam int DEN_WIDTH          = ((PROD_WIDTH > NUM_WIDTH) ? PROD_WIDTH : NUM_WIDTH) + 1;
   localparam int REM_WIDTH          = DEN_WIDTH + 1;
   localparam int EXPO_WIDTH         = LOG_WIDTH + ROLL_WIDTH + 1;
   localparam int SCALED_WIDTH       = EXPO_WIDTH - 8;
   localparam int INT_WIDTH          = SCALED_WIDTH - LOG_FRAC;
   localparam int SHIFT_WIDTH        = INT_WIDTH + 2;
   localparam int DIV_STEPS          = GAIN_FRACTION_BITS + 1;
   localparam int NSTEP              = (DIV_STEPS > LOG_FRAC) ? DIV_STEPS : LOG_FRAC;
   localparam int LATENCY            = NSTEP + LOG_FRAC + 5;
   localparam int QDEPTH             = 2;
   localparam int ADDR_WIDTH         = 4;

   localparam logic [GAIN_WIDTH-1:0] GAIN_ONE = GAIN_WIDTH'(1) << GAIN_FRACTION_BITS;

   localparam logic [MODEL_WIDTH-1:0] MODEL_NONE    = 2'd0;
   localparam logic [MODEL_WIDTH-1:0] MODEL_INVERSE = 2'd1;
   localparam logic [MODEL_WIDTH-1:0] MODEL_LINEAR  = 2'd2;
   localparam logic [MODEL_WIDTH-1:0] MODEL_EXP     = 2'd3;

   localparam logic [1:0] REG_REFERENCE = 2'd0;
   localparam logic [1:0] REG_MAXIMUM   = 2'd1;
   localparam logic [1:0] REG_ROLLOFF   = 2'd2;
   localparam logic [1:0] REG_MODEL     = 2'd3;

   typedef enum logic [4:0] {
      CLS_ONE  = 5'b00001,
      CLS_ZERO = 5'b00010,
      CLS_INV  = 5'b00100,
      CLS_LIN  = 5'b01000,
      CLS_EXP  = 5'b10000
   } cls_type;

   typedef struct packed {
      cls_type                   cls;
      logic [DISTANCE_WIDTH-1:0] distance;
      logic [DISTANCE_WIDTH-1:0] refd;
      logic [DISTANCE_WIDTH-1:0] span;
      logic [ROLL_WIDTH-1:0]     roll;
   } item_type;

   typedef struct packed {
      logic [LOG_WIDTH-1:0]  acc;
      logic [MANT_WIDTH-1:0] mant;
   } log_type;

   function automatic log_type log_init(input logic [DISTANCE_WIDTH-1:0] x);
      logic [POS_WIDTH-1:0]           p;
      logic [DISTANCE_WIDTH+29:0]     wide;
      log_type                        res;
      p = '0;
      for (int i = 0; i < DISTANCE_WIDTH; i++) begin
         if (x[i]) begin
            p = POS_WIDTH'(i);
         end
      end
      wide = {x, 30'b0} >> p;
      res.acc = LOG_WIDTH'(p);
      res.mant = wide[MANT_WIDTH-1:0];
      return res;
   endfunction

   function automatic log_type log_step(input log_type x);
      logic [2*MANT_WIDTH-1:0] sq;
      logic [31:0]             t;
      log_type                 res;
      sq = (2*MANT_WIDTH)'(x.mant) * (2*MANT_WIDTH)'(x.mant);
      t = sq[61:30];
      res.acc = {x.acc[LOG_WIDTH-2:0], t[31]};
      res.mant = t[31] ? t[31:1] : t[30:0];
      return res;
   endfunction

   function automatic logic [63:0] isqrt64(input logic [63:0] n);
      logic [63:0] res;
      logic [63:0] bitv;
      logic [63:0] rem;
      res = '0;
      rem = n;
      bitv = 64'h1 << 62;
      for (int i = 0; i < 32; i++) begin
         if (rem >= res + bitv) begin
            rem = rem - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic logic [MANT_WIDTH-1:0] exp_coef(input int idx);
      logic [63:0] c;
      c = isqrt64(64'h1 << 59);
      for (int j = 2; j <= idx; j++) begin
         c = isqrt64(c << 30);
      end
      return c[MANT_WIDTH-1:0];
   endfunction

endpackage

### rtl/dag_front.sv
// Front part: classifies each distance beat against the configured registers.
// Depends on dag_pkg for the item type and model codes.
module dag_front (
   input  logic [dag_pkg::DISTANCE_WIDTH-1:0] distance,
   input  logic [dag_pkg::DISTANCE_WIDTH-1:0] refd,
   input  logic [dag_pkg::DISTANCE_WIDTH-1:0] maxd,
   input  logic [dag_pkg::ROLL_WIDTH-1:0]     roll,
   input  logic [dag_pkg::MODEL_WIDTH-1:0]    model,
   output dag_pkg::item_type                  item
);

   always_comb begin
      item.distance = distance;
      item.refd = refd;
      item.span = maxd - refd;
      item.roll = roll;
      if (distance <= refd) begin
         item.cls = dag_pkg::CLS_ONE;
      end else if (distance >= maxd) begin
         item.cls = dag_pkg::CLS_ZERO;
      end else begin
         unique case (model)
            dag_pkg::MODEL_NONE:    item.cls = dag_pkg::CLS_ONE;
            dag_pkg::MODEL_INVERSE: item.cls = dag_pkg::CLS_INV;
            dag_pkg::MODEL_LINEAR:  item.cls = dag_pkg::CLS_LIN;
            default:                item.cls = dag_pkg::CLS_EXP;
         endcase
      end
   end

endmodule

### rtl/dag_queue.sv
// Short queue between the classifying front and the arithmetic back.
// Depends on dag_pkg for the item type and depth.
module dag_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  dag_pkg::item_type push_item,
   output logic              full,
   output logic              pop_valid,
   output dag_pkg::item_type pop_item
);

   localparam int PW = $clog2(dag_pkg::QDEPTH);
   localparam int CW = $clog2(dag_pkg::QDEPTH + 1);

   dag_pkg::item_type mem_ff [dag_pkg::QDEPTH];
   logic [PW-1:0]     wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic              pop;

   assign full      = (cnt_ff == CW'(dag_pkg::QDEPTH));
   assign pop_valid = (cnt_ff != '0);
   assign pop       = pop_valid;
   assign pop_item  = mem_ff[rd_ff];

   always_comb begin
      wr_in  = push ? ((wr_ff == PW'(dag_pkg::QDEPTH - 1)) ? '0 : wr_ff + 1'b1) : wr_ff;
      rd_in  = pop ? ((rd_ff == PW'(dag_pkg::QDEPTH - 1)) ? '0 : rd_ff + 1'b1) : rd_ff;
      cnt_in = cnt_ff + CW'(push) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

### rtl/dag_back.sv
// Back part: pipelined divider, logarithm and exponent stages that form the gain.
// Depends on dag_pkg for widths, constants and arithmetic helpers.
module dag_back (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   input  dag_pkg::item_type                  in_item,
   output logic                               out_valid,
   output logic [dag_pkg::GAIN_WIDTH-1:0]     out_gain,
   output logic                               out_sat
);

   localparam int DW  = dag_pkg::DISTANCE_WIDTH;
   localparam int GW  = dag_pkg::GAIN_WIDTH;
   localparam int GFB = dag_pkg::GAIN_FRACTION_BITS;
   localparam int MW  = dag_pkg::MANT_WIDTH;
   localparam int LF  = dag_pkg::LOG_FRAC;

   typedef struct packed {
      logic                                valid;
      dag_pkg::cls_type                    cls;
      logic                                sat;
      logic                                one;
      logic [dag_pkg::REM_WIDTH-1:0]       rem;
      logic [dag_pkg::DEN_WIDTH-1:0]       den;
      logic [GW-1:0]                       quo;
      logic [dag_pkg::ROLL_WIDTH-1:0]      roll;
      logic                                refzero;
      dag_pkg::log_type                    ld;
      dag_pkg::log_type                    lr;
   } step_type;

   typedef struct packed {
      logic                                valid;
      dag_pkg::cls_type                    cls;
      logic                                sat;
      logic [GW-1:0]                       dgain;
      logic                                refzero;
      logic                                rollzero;
      logic [dag_pkg::INT_WIDTH-1:0]       k;
      logic [LF-1:0]                       f;
      logic [MW-1:0]                       m;
   } exp_type;

   logic                              p1_valid_ff;
   dag_pkg::item_type                 p1_item_ff;
   logic [dag_pkg::PROD_WIDTH-1:0]    p1_prod_ff;
   logic [DW-1:0]                     diff;

   step_type                          st_in;
   step_type                          st_ff [0:dag_pkg::NSTEP];
   exp_type                           ex_in;
   exp_type                           ex_ff [0:LF];

   logic [dag_pkg::DEN_WIDTH-1:0]     num_inv, den_inv, num_lin, den_lin, num_sel, den_sel;
   logic [dag_pkg::LOG_WIDTH-1:0]     lsub;
   logic [dag_pkg::EXPO_WIDTH-1:0]    expo;
   logic [dag_pkg::SCALED_WIDTH-1:0]  scaled;

   logic [dag_pkg::SHIFT_WIDTH-1:0]   sh;
   logic [41:0]                       rsum, rshift;
   logic [GW-1:0]                     gexp, gain_in;
   logic                              valid_ff, sat_ff, sat_in;
   logic [GW-1:0]                     gain_ff;

   assign diff = in_item.distance - in_item.refd;

   always_ff @(posedge clock) begin
      p1_item_ff <= in_item;
      p1_prod_ff <= dag_pkg::PROD_WIDTH'(in_item.roll) * dag_pkg::PROD_WIDTH'(diff);
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff <= in_valid;
      end
   end

   always_comb begin
      num_inv = dag_pkg::DEN_WIDTH'({p1_item_ff.refd, 8'b0});
      den_inv = num_inv + dag_pkg::DEN_WIDTH'(p1_prod_ff);
      num_lin = dag_pkg::DEN_WIDTH'(p1_prod_ff);
      den_lin = dag_pkg::DEN_WIDTH'({p1_item_ff.span, 8'b0});
      num_sel = (p1_item_ff.cls == dag_pkg::CLS_LIN) ? num_lin : num_inv;
      den_sel = (p1_item_ff.cls == dag_pkg::CLS_LIN) ? den_lin : den_inv;
      st_in.valid   = p1_valid_ff;
      st_in.cls     = p1_item_ff.cls;
      st_in.sat     = (p1_item_ff.cls == dag_pkg::CLS_LIN) && (num_lin > den_lin);
      st_in.one     = (num_sel >= den_sel);
      st_in.rem     = dag_pkg::REM_WIDTH'(num_sel);
      st_in.den     = den_sel;
      st_in.quo     = '0;
      st_in.roll    = p1_item_ff.roll;
      st_in.refzero = (p1_item_ff.refd == '0);
      st_in.ld      = dag_pkg::log_init(p1_item_ff.distance);
      st_in.lr      = dag_pkg::log_init(p1_item_ff.refd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff[0] <= '0;
      end else begin
         st_ff[0] <= st_in;
      end
   end

   for (genvar i = 0; i < dag_pkg::NSTEP; i++) begin : g_step
      step_type                      cur, nxt;
      logic [dag_pkg::REM_WIDTH-1:0] r2;
      logic                          ge;
      assign cur = st_ff[i];
      assign r2  = {cur.rem[dag_pkg::REM_WIDTH-2:0], 1'b0};
      assign ge  = (r2 >= dag_pkg::REM_WIDTH'(cur.den));
      always_comb begin
         nxt = cur;
         if (i < GFB) begin
            nxt.quo = {cur.quo[GW-2:0], ge};
            nxt.rem = ge ? (r2 - dag_pkg::REM_WIDTH'(cur.den)) : r2;
         end else if (i == GFB) begin
            nxt.quo = cur.quo + GW'(ge);
         end
         if (i < LF) begin
            nxt.ld = dag_pkg::log_step(cur.ld);
            nxt.lr = dag_pkg::log_step(cur.lr);
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            st_ff[i+1] <= '0;
         end else begin
            st_ff[i+1] <= nxt;
         end
      end
   end

   always_comb begin
      step_type s;
      s = st_ff[dag_pkg::NSTEP];
      lsub = (s.ld.acc > s.lr.acc) ? (s.ld.acc - s.lr.acc) : '0;
      expo = dag_pkg::EXPO_WIDTH'(s.roll) * dag_pkg::EXPO_WIDTH'(lsub)
             + dag_pkg::EXPO_WIDTH'(128);
      scaled = expo[dag_pkg::EXPO_WIDTH-1:8];
      ex_in.valid    = s.valid;
      ex_in.cls      = s.cls;
      ex_in.sat      = s.sat;
      ex_in.refzero  = s.refzero;
      ex_in.rollzero = (s.roll == '0);
      ex_in.k        = scaled[dag_pkg::SCALED_WIDTH-1:LF];
      ex_in.f        = scaled[LF-1:0];
      ex_in.m        = MW'(1) << 30;
      if (s.cls == dag_pkg::CLS_LIN) begin
         ex_in.dgain = (s.sat || s.one) ? '0 : (dag_pkg::GAIN_ONE - s.quo);
      end else begin
         ex_in.dgain = s.one ? dag_pkg::GAIN_ONE : s.quo;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ex_ff[0] <= '0;
      end else begin
         ex_ff[0] <= ex_in;
      end
   end

   for (genvar i = 0; i < LF; i++) begin : g_exp
      localparam logic [MW-1:0] COEF = dag_pkg::exp_coef(i + 1);
      exp_type             cur, nxt;
      logic [2*MW-1:0]     prod;
      assign cur  = ex_ff[i];
      assign prod = (2*MW)'(cur.m) * (2*MW)'(COEF);
      always_comb begin
         nxt = cur;
         if (cur.f[LF-1-i]) begin
            nxt.m = prod[MW+29:30];
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            ex_ff[i+1] <= '0;
         end else begin
            ex_ff[i+1] <= nxt;
         end
      end
   end

   always_comb begin
      exp_type e;
      e = ex_ff[LF];
      sh = dag_pkg::SHIFT_WIDTH'(30 - GFB) + dag_pkg::SHIFT_WIDTH'(e.k);
      rsum = 42'(e.m) + (42'd1 << (sh - 1'b1));
      rshift = rsum >> sh;
      if (e.refzero) begin
         gexp = e.rollzero ? dag_pkg::GAIN_ONE : '0;
      end else if (sh > dag_pkg::SHIFT_WIDTH'(40)) begin
         gexp = '0;
      end else if (rshift > 42'(dag_pkg::GAIN_ONE)) begin
         gexp = dag_pkg::GAIN_ONE;
      end else begin
         gexp = rshift[GW-1:0];
      end
      sat_in = e.sat;
      unique case (e.cls)
         dag_pkg::CLS_ONE:  gain_in = dag_pkg::GAIN_ONE;
         dag_pkg::CLS_ZERO: gain_in = '0;
         dag_pkg::CLS_INV:  gain_in = e.dgain;
         dag_pkg::CLS_LIN:  gain_in = e.dgain;
         default:           gain_in = gexp;
      endcase
   end

   always_ff @(posedge clock) begin
      gain_ff <= gain_in;
      sat_ff  <= sat_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= ex_ff[LF].valid;
      end
   end

   assign out_valid = valid_ff;
   assign out_gain  = gain_ff;
   assign out_sat   = sat_ff;

endmodule

### rtl/distance_attenuation_gain.sv
// Top level of the distance attenuation gain block: register file and part wiring.
// Depends on dag_pkg, dag_front, dag_queue and dag_back.

// One distance beat may be started in every cycle; busy only rises if the internal queue
// fills, which never happens because the arithmetic pipeline drains it every cycle. Each
// beat yields exactly one gain beat on rsp_valid. It passes, in order, the queue, the rolloff
// product register, the register that sets up the division and logarithms, sixteen divider
// and logarithm stages, the register that forms the exponent, sixteen exponent multiply
// stages and the output register that shows the gain beat. The receiver cannot stall.
module distance_attenuation_gain (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [dag_pkg::DISTANCE_WIDTH-1:0]  req_source_distance,
   output logic                                rsp_valid,
   output logic [dag_pkg::GAIN_WIDTH-1:0]      rsp_gain,
   output logic                                rsp_saturated,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [dag_pkg::ADDR_WIDTH-1:0]      paddr,
   input  logic [31:0]                         pwdata,
   output logic [31:0]                         prdata,
   output logic                                pready
);

   logic [dag_pkg::DISTANCE_WIDTH-1:0] ref_ff, max_ff;
   logic [dag_pkg::ROLL_WIDTH-1:0]     roll_ff;
   logic [dag_pkg::MODEL_WIDTH-1:0]    model_ff;
   logic                               wr_en, accept, full, pop_valid;
   logic [1:0]                         reg_idx;
   dag_pkg::item_type                  front_item, pop_item;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = paddr[3:2];
   assign busy    = full;
   assign accept  = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_ff   <= dag_pkg::DISTANCE_WIDTH'(256);
         max_ff   <= '1;
         roll_ff  <= dag_pkg::ROLL_WIDTH'(256);
         model_ff <= dag_pkg::MODEL_INVERSE;
      end else if (wr_en) begin
         unique case (reg_idx)
            dag_pkg::REG_REFERENCE: ref_ff   <= pwdata[dag_pkg::DISTANCE_WIDTH-1:0];
            dag_pkg::REG_MAXIMUM:   max_ff   <= pwdata[dag_pkg::DISTANCE_WIDTH-1:0];
            dag_pkg::REG_ROLLOFF:   roll_ff  <= pwdata[dag_pkg::ROLL_WIDTH-1:0];
            default:                model_ff <= pwdata[dag_pkg::MODEL_WIDTH-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         dag_pkg::REG_REFERENCE: prdata = 32'(ref_ff);
         dag_pkg::REG_MAXIMUM:   prdata = 32'(max_ff);
         dag_pkg::REG_ROLLOFF:   prdata = 32'(roll_ff);
         default:                prdata = 32'(model_ff);
      endcase
   end

   dag_front u_front (
      .distance (req_source_distance),
      .refd     (ref_ff),
      .maxd     (max_ff),
      .roll     (roll_ff),
      .model    (model_ff),
      .item     (front_item)
   );

   dag_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_item (front_item),
      .full      (full),
      .pop_valid (pop_valid),
      .pop_item  (pop_item)
   );

   dag_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (pop_valid),
      .in_item   (pop_item),
      .out_valid (rsp_valid),
      .out_gain  (rsp_gain),
      .out_sat   (rsp_saturated)
   );

   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##(dag_pkg::LATENCY) rsp_valid)
      else $error("gain beat missing after a started distance beat");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_gain <= dag_pkg::GAIN_ONE))
      else $error("gain above unity");

   a_sat: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_saturated) |-> (rsp_gain == '0))
      else $error("saturated beat with nonzero gain");

endmodule

### test/distance_attenuation_gain_checker.sv
`timescale 1ns / 1ps
// Gain checker for the distance attenuation gain block: watches the distance and gain beats.
// Predicts every gain from its own copy of the registers and compares in order; uses dag_pkg.
module distance_attenuation_gain_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic                               busy,
   input  logic [dag_pkg::DISTANCE_WIDTH-1:0] req_source_distance,
   input  logic                               rsp_valid,
   input  logic [dag_pkg::GAIN_WIDTH-1:0]     rsp_gain,
   input  logic                               rsp_saturated,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [dag_pkg::ADDR_WIDTH-1:0]     paddr,
   input  logic [31:0]                        pwdata,
   input  logic                               pready,
   output int                                 fail_count,
   output int                                 gains_pending
);

   typedef struct packed {
      logic [dag_pkg::GAIN_WIDTH-1:0] gain;
      logic                           sat;
   } gain_beat_type;

   logic [23:0]   ref_dist, max_dist;
   logic [15:0]   rolloff;
   logic [1:0]    model;
   gain_beat_type gain_fifo[$];

   assign gains_pending = gain_fifo.size();

   function automatic logic [63:0] root64(input logic [63:0] n);
      logic [63:0] r, b;
      r = 0;
      b = 64'h1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n = n - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic logic [63:0] ratio_q15(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] q, r;
      q = 0;
      r = num;
      if (den == 0 || r >= den) return 64'(dag_pkg::GAIN_ONE);
      for (int i = 0; i < dag_pkg::GAIN_FRACTION_BITS; i++) begin
         r = r << 1;
         q = q << 1;
         if (r >= den) begin
            r = r - den;
            q = q | 1;
         end
      end
      r = r << 1;
      if (r >= den) q = q + 1;
      return q;
   endfunction

   function automatic logic [63:0] log2_q16(input logic [63:0] x);
      int p;
      logic [63:0] m, acc;
      p = 63;
      while (p > 0 && x[p] == 1'b0) p--;
      m = (p <= 30) ? (x << (30 - p)) : (x >> (p - 30));
      acc = 64'(p);
      for (int i = 0; i < 16; i++) begin
         m = (m * m) >> 30;
         acc = acc << 1;
         if (m >= (64'd2 << 30)) begin
            m = m >> 1;
            acc = acc | 1;
         end
      end
      return acc;
   endfunction

   function automatic logic [63:0] power_gain(input logic [63:0] d, input logic [63:0] r,
                                              input logic [63:0] roll);
      logic [63:0] ld, lr, l, e, f, k, m, c, s;
      if (r == 0) return (roll == 0) ? 64'(dag_pkg::GAIN_ONE) : 0;
      ld = log2_q16(d);
      lr = log2_q16(r);
      l = (ld > lr) ? ld - lr : 0;
      e = (roll * l + 128) >> 8;
      k = e >> 16;
      f = e & 64'hFFFF;
      m = 64'h1 << 30;
      c = root64(64'h1 << 59);
      for (int i = 1; i <= 16; i++) begin
         if (f[16 - i]) m = (m * c) >> 30;
         c = root64(c << 30);
      end
      if (k > 40) return 0;
      s = 30 - dag_pkg::GAIN_FRACTION_BITS + k;
      if (s > 40) return 0;
      m = (m + (64'h1 << (s - 1))) >> s;
      return (m > dag_pkg::GAIN_ONE) ? 64'(dag_pkg::GAIN_ONE) : m;
   endfunction

   function automatic gain_beat_type attenuate(input logic [23:0] dval);
      logic [63:0] d, r, mx, roll, g, num, den;
      gain_beat_type res;
      d = 64'(dval);
      r = 64'(ref_dist);
      mx = 64'(max_dist);
      roll = 64'(rolloff);
      res.sat = 1'b0;
      g = 64'(dag_pkg::GAIN_ONE);
      if (d <= r) begin
         g = 64'(dag_pkg::GAIN_ONE);
      end else if (d >= mx) begin
         g = 0;
      end else if (model == dag_pkg::MODEL_INVERSE) begin
         den = (r << 8) + roll * (d - r);
         if (den == 0) g = (roll == 0) ? 64'(dag_pkg::GAIN_ONE) : 0;
         else g = ratio_q15(r << 8, den);
      end else if (model == dag_pkg::MODEL_LINEAR) begin
         num = roll * (d - r);
         den = (mx - r) << 8;
         if (den == 0) begin
            g = (roll == 0) ? 64'(dag_pkg::GAIN_ONE) : 0;
         end else if (num > den) begin
            g = 0;
            res.sat = 1'b1;
         end else begin
            g = 64'(dag_pkg::GAIN_ONE) - ratio_q15(num, den);
         end
      end else if (model == dag_pkg::MODEL_EXP) begin
         g = power_gain(d, r, roll);
      end
      if (g > dag_pkg::GAIN_ONE) g = 64'(dag_pkg::GAIN_ONE);
      res.gain = g[dag_pkg::GAIN_WIDTH-1:0];
      return res;
   endfunction

   task automatic report_mismatch(input string what);
      $display("%0t: gain mismatch: %s", $realtime, what);
      fail_count++;
   endtask

   always @(posedge clock) begin
      gain_beat_type want;
      if (reset) begin
         ref_dist <= 24'd256;
         max_dist <= 24'hFFFFFF;
         rolloff <= 16'd256;
         model <= dag_pkg::MODEL_INVERSE;
         fail_count <= 0;
         gain_fifo.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[3:2])
               dag_pkg::REG_REFERENCE: ref_dist <= pwdata[23:0];
               dag_pkg::REG_MAXIMUM:   max_dist <= pwdata[23:0];
               dag_pkg::REG_ROLLOFF:   rolloff <= pwdata[15:0];
               dag_pkg::REG_MODEL:     model <= pwdata[1:0];
            endcase
         end
         if (start && !busy) gain_fifo = {gain_fifo, attenuate(req_source_distance)};
         if (rsp_valid) begin
            if (gain_fifo.size() == 0) begin
               report_mismatch("gain beat with none expected");
            end else begin
               want = gain_fifo.pop_front();
               if (rsp_gain !== want.gain)
                  report_mismatch($sformatf("gain %0d, expected %0d", rsp_gain, want.gain));
               if (rsp_saturated !== want.sat)
                  report_mismatch($sformatf("saturated %0b, expected %0b",
                                            rsp_saturated, want.sat));
            end
         end
      end
   end
endmodule

### test/distance_attenuation_gain_tb.sv
`timescale 1ns / 1ps
// Top of the distance attenuation gain testbench: clock, reset, register writes and distances.
// Depends on dag_pkg, the block and distance_attenuation_gain_checker.
module distance_attenuation_gain_tb;

   localparam int IDLE_LIMIT = 5000;

   logic        clock, reset, start, busy, rsp_valid, rsp_saturated;
   logic        psel, penable, pwrite, pready;
   logic [23:0] req_source_distance;
   logic [dag_pkg::GAIN_WIDTH-1:0] rsp_gain;
   logic [dag_pkg::ADDR_WIDTH-1:0] paddr;
   logic [31:0] pwdata, prdata;
   int          fail_count, gains_pending, idle_cycles;
   logic [23:0] cur_ref, cur_max;

   distance_attenuation_gain dut (.*);

   distance_attenuation_gain_checker checker_i (.*);

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || psel) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic drain();
      while (gains_pending != 0) @(posedge clock);
      repeat (dag_pkg::LATENCY + 5) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] val);
      psel <= 1;
      penable <= 0;
      pwrite <= 1;
      paddr <= dag_pkg::ADDR_WIDTH'({idx, 2'b00});
      pwdata <= val;
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      psel <= 0;
      penable <= 0;
      pwrite <= 0;
   endtask

   task automatic configure(input logic [23:0] r, input logic [23:0] mx,
                            input logic [15:0] roll, input logic [1:0] mdl);
      start <= 0;
      drain();
      csr_write(dag_pkg::REG_REFERENCE, 32'(r));
      csr_write(dag_pkg::REG_MAXIMUM, 32'(mx));
      csr_write(dag_pkg::REG_ROLLOFF, 32'(roll));
      csr_write(dag_pkg::REG_MODEL, 32'(mdl));
      cur_ref = r;
      cur_max = mx;
   endtask

   task automatic send_distance(input logic [23:0] d);
      start <= 1;
      req_source_distance <= d;
      do @(posedge clock); while (busy);
   endtask

   function automatic logic [23:0] pick_distance();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel == 0) return 24'($urandom());
      if (sel == 1) return cur_ref + 24'($urandom_range(0, 2)) - 24'd1;
      if (sel == 2) return cur_max + 24'($urandom_range(0, 2)) - 24'd1;
      if (cur_max > cur_ref)
         return cur_ref + 24'($urandom_range(0, cur_max - cur_ref));
      return 24'($urandom());
   endfunction

   task automatic random_phase(input int count);
      int left, burst;
      left = count;
      while (left > 0) begin
         burst = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 12);
         for (int i = 0; i < burst && left > 0; i++) begin
            send_distance(pick_distance());
            left--;
         end
         start <= 0;
         repeat ($urandom_range(0, 6)) @(posedge clock);
      end
      start <= 0;
      @(posedge clock);
   endtask

   initial begin
      logic [23:0] r, mx;
      reset = 1;
      start = 0;
      req_source_distance = 0;
      psel = 0;
      penable = 0;
      pwrite = 0;
      paddr = 0;
      pwdata = 0;
      cur_ref = 24'd256;
      cur_max = 24'hFFFFFF;
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      send_distance(24'd0);
      send_distance(24'hFFFFFF);
      send_distance(24'd256);
      send_distance(24'd257);
      send_distance(24'd1024);
      start <= 0;
      @(posedge clock);
      drain();
      configure(24'd256, 24'd4096, 16'd512, dag_pkg::MODEL_LINEAR);
      send_distance(24'd4000);
      send_distance(24'd2176);
      send_distance(24'd2177);
      send_distance(24'd4096);
      configure(24'd0, 24'd4096, 16'd0, dag_pkg::MODEL_INVERSE);
      send_distance(24'd100);
      configure(24'd0, 24'd4096, 16'd300, dag_pkg::MODEL_EXP);
      send_distance(24'd100);
      configure(24'd0, 24'd4096, 16'd0, dag_pkg::MODEL_EXP);
      send_distance(24'd100);
      configure(24'd300, 24'd300, 16'd256, dag_pkg::MODEL_LINEAR);
      send_distance(24'd300);
      send_distance(24'd301);
      configure(24'd1, 24'hFFFFFF, 16'hFFFF, dag_pkg::MODEL_EXP);
      send_distance(24'hFFFFFE);
      send_distance(24'd2);
      configure(24'd256, 24'hFFFFFF, 16'd256, dag_pkg::MODEL_NONE);
      send_distance(24'd5000);
      configure(24'hFFFFFF, 24'd0, 16'hFFFF, dag_pkg::MODEL_INVERSE);
      send_distance(24'hFFFFFF);
      start <= 0;
      @(posedge clock);
      drain();
      for (int phase = 0; phase < 14; phase++) begin
         r = (phase % 4 == 0) ? 24'($urandom()) : 24'($urandom_range(0, 4096));
         mx = (phase % 5 == 0) ? 24'hFFFFFF : r + 24'($urandom_range(0, 1 << 20));
         configure(r, mx,
                   (phase % 3 == 0) ? 16'($urandom()) : 16'($urandom_range(0, 1024)),
                   2'(phase));
         random_phase(125);
         drain();
      end
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule

### sim.f
rtl/dag_pkg.sv
rtl/dag_front.sv
rtl/dag_queue.sv
rtl/dag_back.sv
rtl/distance_attenuation_gain.sv
test/distance_attenuation_gain_checker.sv
test/distance_attenuation_gain_tb.sv
